>>> rtl/bbfd_pkg.sv
// shared types and constants of the beast binary frame deframer
package bbfd_pkg;

   localparam logic [7:0] ESC_BYTE       = 8'h1A;
   localparam logic [7:0] TYPE_MODEAC    = 8'h31;
   localparam logic [7:0] TYPE_SHORT     = 8'h32;
   localparam logic [7:0] TYPE_LONG      = 8'h33;

   localparam int STORE_DEPTH = 14;
   localparam int LANE_BYTES  = 7;
   localparam int STAMP_BYTES = 6;
   localparam int LANE_W      = 8 * LANE_BYTES;

   localparam logic [3:0] LONG_PAYLOAD_BYTES   = 4'd14;
   localparam logic [3:0] SHORT_PAYLOAD_BYTES  = 4'd7;
   localparam logic [3:0] MODEAC_PAYLOAD_BYTES = 4'd2;
   localparam logic [3:0] STAMP_LAST           = 4'(STAMP_BYTES - 1);

   // frame type codes on the result
   localparam logic [1:0] FT_MODEAC = 2'd0;
   localparam logic [1:0] FT_SHORT  = 2'd1;
   localparam logic [1:0] FT_LONG   = 2'd2;

   localparam int RSP_DATA_W = 176;

   // kind of a body byte handed from front to back
   typedef enum logic [1:0] {
      EV_STAMP   = 2'd0,
      EV_SIGNAL  = 2'd1,
      EV_PAYLOAD = 2'd2
   } event_kind_type;

   // one body byte, classified by the front end
   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     data;
      logic [3:0]     index;
      logic           last;
      logic           emit;
      logic [1:0]     frame_type;
   } body_event_type;

   // payload length of a frame type
   function automatic logic [3:0] type_length(input logic [1:0] ft);
      logic [3:0] len;
      case (ft)
         FT_MODEAC: len = MODEAC_PAYLOAD_BYTES;
         FT_SHORT:  len = SHORT_PAYLOAD_BYTES;
         default:   len = LONG_PAYLOAD_BYTES;
      endcase
      return len;
   endfunction

endpackage

>>> rtl/bbfd_front.sv
// front end: escape handling, frame phase tracking and byte classification
module bbfd_front
   import bbfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           byte_valid,
   input  logic [7:0]     byte_data,
   input  logic           accept_mode_ac,
   output logic           push,
   output body_event_type push_event
);

   typedef enum logic [4:0] {
      PH_HUNT    = 5'b00001,
      PH_TYPE    = 5'b00010,
      PH_STAMP   = 5'b00100,
      PH_SIGNAL  = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       skip_ff, skip_in;
   logic [3:0] count_ff, count_in;
   logic [1:0] type_ff, type_in;

   logic       is_esc;
   logic [3:0] count_next;
   logic       pay_last;

   assign is_esc     = (byte_data == ESC_BYTE);
   assign count_next = count_ff + 4'd1;
   assign pay_last   = (count_next == type_length(type_ff));

   // phase update for one transferred byte
   always_comb begin
      phase_in = phase_ff;
      skip_in  = skip_ff;
      count_in = count_ff;
      type_in  = type_ff;
      push     = 1'b0;
      push_event.kind       = EV_STAMP;
      push_event.data       = byte_data;
      push_event.index      = count_ff;
      push_event.last       = 1'b0;
      push_event.emit       = 1'b0;
      push_event.frame_type = type_ff;
      if (byte_valid) begin
         if (skip_ff) begin
            skip_in = 1'b0;
         end else begin
            case (phase_ff)
               PH_HUNT: begin
                  if (is_esc) phase_in = PH_TYPE;
               end
               PH_TYPE: begin
                  if (!is_esc) begin
                     count_in = 4'd0;
                     phase_in = PH_STAMP;
                     case (byte_data)
                        TYPE_MODEAC: type_in = FT_MODEAC;
                        TYPE_SHORT:  type_in = FT_SHORT;
                        TYPE_LONG:   type_in = FT_LONG;
                        default:     phase_in = PH_HUNT;
                     endcase
                  end
               end
               PH_STAMP: begin
                  push     = 1'b1;
                  skip_in  = is_esc;
                  count_in = count_next;
                  if (count_ff == STAMP_LAST) begin
                     count_in = 4'd0;
                     phase_in = PH_SIGNAL;
                  end
               end
               PH_SIGNAL: begin
                  push            = 1'b1;
                  push_event.kind = EV_SIGNAL;
                  skip_in         = is_esc;
                  count_in        = 4'd0;
                  phase_in        = PH_PAYLOAD;
               end
               PH_PAYLOAD: begin
                  push            = 1'b1;
                  push_event.kind = EV_PAYLOAD;
                  push_event.last = pay_last;
                  push_event.emit = pay_last &&
                                    ((type_ff != FT_MODEAC) || accept_mode_ac);
                  skip_in         = is_esc;
                  count_in        = count_next;
                  if (pay_last) begin
                     count_in = 4'd0;
                     phase_in = PH_HUNT;
                  end
               end
               default: begin
                  phase_in = PH_HUNT;
                  count_in = 4'd0;
               end
            endcase
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         skip_ff  <= 1'b0;
         count_ff <= 4'd0;
         type_ff  <= FT_MODEAC;
      end else begin
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         count_ff <= count_in;
         type_ff  <= type_in;
      end
   end

endmodule

>>> rtl/bbfd_queue.sv
// two-entry queue of classified body bytes between front and back
module bbfd_queue
   import bbfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  body_event_type push_event,
   output logic           full,
   output logic           pop_valid,
   input  logic           pop,
   output body_event_type pop_event
);

   body_event_type slot_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_event = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_event;
   end

endmodule

>>> rtl/bbfd_back.sv
// back end: frame field assembly and result output register
module bbfd_back
   import bbfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ev_valid,
   input  body_event_type        ev,
   output logic                  ev_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser
);

   logic [47:0] stamp_ff;
   logic [7:0]  signal_ff;
   logic [7:0]  store_ff [STORE_DEPTH];
   logic        out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic [1:0]  out_user_ff;

   logic        out_free;
   logic        load;
   logic [3:0]  len;
   logic [7:0]  cur_byte [STORE_DEPTH];
   logic [LANE_W-1:0] upper, lower;

   assign out_free = !out_valid_ff || rsp_tready;
   // only an emitted frame end needs room in the output register
   assign ev_pop   = ev_valid && (!(ev.last && ev.emit) || out_free);
   assign load     = ev_pop && ev.last && ev.emit;
   assign len      = type_length(ev.frame_type);

   // payload bytes with the current byte merged in, masked beyond the length
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         cur_byte[i] = (ev.kind == EV_PAYLOAD && ev.index == 4'(i)) ? ev.data
                                                                    : store_ff[i];
         if (4'(i) >= len) cur_byte[i] = 8'd0;
      end
      for (int i = 0; i < LANE_BYTES; i++) begin
         upper[LANE_W-1-8*i -: 8] = cur_byte[i];
         lower[LANE_W-1-8*i -: 8] = cur_byte[LANE_BYTES+i];
      end
   end

   // field registers
   always_ff @(posedge clock) begin
      if (ev_pop) begin
         case (ev.kind)
            EV_STAMP:   stamp_ff  <= {stamp_ff[39:0], ev.data};
            EV_SIGNAL:  signal_ff <= ev.data;
            EV_PAYLOAD: store_ff[ev.index] <= ev.data;
            default:    signal_ff <= signal_ff;
         endcase
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) out_valid_in = 1'b0;
      if (load) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= {4'b0000, lower, upper, len, signal_ff, stamp_ff};
         out_user_ff <= ev.frame_type;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

>>> rtl/beast_binary_frame_deframer_unit.sv
// Beast binary stream deframer: takes escaped stream bytes, emits one
// result per complete Mode A/C, short or long Mode S frame.
//
// req channel: one raw stream byte per transfer in req_tdata.
// rsp channel: one transfer per complete frame (Mode A/C only when
//   accept_mode_ac is set). Body escapes are undone; the frame type travels
//   in rsp_tuser, timestamp and payload are packed as listed at rsp_tdata.
// csr port: register accept_mode_ac at byte address 0, bit 0.
// Throughput: one byte per cycle while req_tready is high. The front end
//   parses every byte in the cycle it is transferred; the two-entry queue and
//   back end drain one body byte per cycle unless an emitted frame end stalls.
// After the last payload byte is transferred, its frame end passes through the
//   queue before the result is loaded into the output register.
// When rsp_tready is low, a finished result waits in the output register
//   while further bytes keep flowing until the next emitted frame end reaches
//   the back end; then the queue fills and req_tready drops.
// Reset clears the parser to hunting for the escape byte, empties the
//   queue and output register and clears accept_mode_ac.
module beast_binary_frame_deframer_unit
   import bbfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [47:0] time_stamp, [55:48] signal_level, [59:56] payload_length,
   // [115:60] payload_upper, [171:116] payload_lower, [175:172] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,   // [1:0] frame_type
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic           accept_ff, accept_in;
   logic           csr_hit;
   logic           q_full, q_push, q_valid, q_pop;
   body_event_type q_in_event, q_out_event;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == 1'b0);
   assign accept_in  = (csr_psel && csr_penable && csr_pwrite && csr_hit) ?
                       csr_pwdata[0] : accept_ff;
   assign csr_prdata = {31'd0, accept_ff && csr_hit};

   always_ff @(posedge clock) begin
      if (reset) accept_ff <= 1'b0;
      else       accept_ff <= accept_in;
   end

   assign req_tready = !q_full;

   bbfd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .byte_valid     (req_tvalid && req_tready),
      .byte_data      (req_tdata),
      .accept_mode_ac (accept_ff),
      .push           (q_push),
      .push_event     (q_in_event)
   );

   bbfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_event (q_in_event),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_event  (q_out_event)
   );

   bbfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .ev_valid   (q_valid),
      .ev         (q_out_event),
      .ev_pop     (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> test/beast_binary_frame_deframer_unit_tb.sv
// testbench for the beast binary frame deframer: escaped streams against a frame predictor
`timescale 1ns / 1ps

module beast_binary_frame_deframer_unit_tb;
   import bbfd_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_BYTES  = 300;
   localparam int PHASES       = 6;
   localparam logic [2:0] ACCEPT_MODE_AC_ADDR = 3'd0;

   // parser position of the predictor
   typedef enum logic [2:0] {
      HUNT_ESC,
      GET_TYPE,
      GET_STAMP,
      GET_SIGNAL,
      GET_PAYLOAD
   } parse_step_type;

   // one decoded frame as it should leave the block
   typedef struct {
      logic [1:0]  frame_type;
      logic [47:0] time_stamp;
      logic [7:0]  signal_level;
      logic [3:0]  payload_length;
      logic [55:0] payload_upper;
      logic [55:0] payload_lower;
   } deframed_type;

   // frame predictor and queue of frames still owed by the block
   class frame_scoreboard;
      bit             accept_ac;
      parse_step_type step;
      bit             drop_next;
      logic [3:0]     count;
      logic [1:0]     cur_type;
      logic [47:0]    stamp;
      logic [7:0]     level;
      logic [7:0]     payload [STORE_DEPTH];
      deframed_type   owed [$];
      int             errors;

      function new();
         accept_ac = 0;
         step      = HUNT_ESC;
         drop_next = 0;
         count     = '0;
         cur_type  = FT_MODEAC;
         stamp     = '0;
         level     = '0;
         errors    = 0;
         foreach (payload[i]) payload[i] = '0;
      endfunction

      function void set_accept(bit v);
         accept_ac = v;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      function logic [3:0] frame_len(logic [1:0] ft);
         if (ft == FT_MODEAC) return MODEAC_PAYLOAD_BYTES;
         if (ft == FT_SHORT) return SHORT_PAYLOAD_BYTES;
         return LONG_PAYLOAD_BYTES;
      endfunction

      // seven payload bytes from position first, zero beyond the frame length
      function logic [55:0] lane(int first, logic [3:0] len);
         logic [55:0] acc;
         acc = '0;
         for (int i = 0; i < LANE_BYTES; i++)
            acc = {acc[47:0], (first + i < len) ? payload[first + i] : 8'h00};
         return acc;
      endfunction

      // advance the parser by one accepted stream byte
      function void note_byte(logic [7:0] b);
         logic [3:0]   len;
         deframed_type f;
         if (drop_next) begin
            drop_next = 0;
            return;
         end
         case (step)
            HUNT_ESC: begin
               if (b == ESC_BYTE) step = GET_TYPE;
            end
            GET_TYPE: begin
               if (b == ESC_BYTE) return;
               if (b == TYPE_MODEAC) cur_type = FT_MODEAC;
               else if (b == TYPE_SHORT) cur_type = FT_SHORT;
               else if (b == TYPE_LONG) cur_type = FT_LONG;
               else begin
                  step = HUNT_ESC;
                  return;
               end
               step  = GET_STAMP;
               count = '0;
               stamp = '0;
               level = '0;
            end
            GET_STAMP: begin
               stamp = {stamp[39:0], b};
               if (b == ESC_BYTE) drop_next = 1;
               count = count + 1;
               if (count >= STAMP_BYTES) begin
                  count = '0;
                  step  = GET_SIGNAL;
               end
            end
            GET_SIGNAL: begin
               level = b;
               if (b == ESC_BYTE) drop_next = 1;
               count = '0;
               step  = GET_PAYLOAD;
            end
            default: begin
               len = frame_len(cur_type);
               if (count < STORE_DEPTH) payload[count] = b;
               if (b == ESC_BYTE) drop_next = 1;
               count = count + 1;
               if (count < len) return;
               count = '0;
               step  = HUNT_ESC;
               // mode a/c frames vanish unless enabled at their last byte
               if (cur_type == FT_MODEAC && !accept_ac) return;
               f.frame_type     = cur_type;
               f.time_stamp     = stamp;
               f.signal_level   = level;
               f.payload_length = len;
               f.payload_upper  = lane(0, len);
               f.payload_lower  = lane(LANE_BYTES, len);
               owed.push_back(f);
            end
         endcase
      endfunction

      function void compare(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
         end
      endfunction

      // match one result transfer against the oldest owed frame
      function void check_result(logic [1:0] u, logic [RSP_DATA_W-1:0] d);
         deframed_type f;
         if (owed.size() == 0) begin
            errors++;
            $display("%0t: unexpected result expected none actual %h %h", $time, u, d);
            return;
         end
         f = owed.pop_front();
         compare("frame_type", f.frame_type, u);
         compare("time_stamp", f.time_stamp, d[47:0]);
         compare("signal_level", f.signal_level, d[55:48]);
         compare("payload_length", f.payload_length, d[59:56]);
         compare("payload_upper", f.payload_upper, d[115:60]);
         compare("payload_lower", f.payload_lower, d[171:116]);
         compare("padding", 64'd0, d[175:172]);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [2:0]            csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   frame_scoreboard sb = new();
   logic [7:0] stream_bytes [$];
   int  frame_bytes;
   int  csr_errors = 0;
   int  cycle_count = 0;
   bit  sender_gaps = 1;
   bit  receiver_gaps = 1;
   bit  hold_request = 0;
   bit  accept_plan [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

   beast_binary_frame_deframer_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result transfers
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 0;
         end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 6);
            rsp_tready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // one stream byte, waiting for its transfer
   task automatic send_byte(input logic [7:0] b);
      int n;
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 6);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      sb.note_byte(b);
   endtask

   task automatic send_stream();
      while (stream_bytes.size() > 0) send_byte(stream_bytes.pop_front());
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // hold off until nothing is owed, then let the back end settle
   task automatic wait_drained();
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input bit v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ACCEPT_MODE_AC_ADDR;
      csr_pwdata  <= {31'($urandom), v};
      @(negedge clock);
      csr_penable <= 1'b1;
      forever begin
         @(posedge clock);
         if (csr_pready) break;
      end
      sb.set_accept(v);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_read_check(input bit v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ACCEPT_MODE_AC_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      forever begin
         @(posedge clock);
         if (csr_pready) break;
      end
      if (csr_prdata !== {31'd0, v}) begin
         csr_errors++;
         $display("%0t: accept_mode_ac read expected %h actual %h", $time,
                  {31'd0, v}, csr_prdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_accept_mode(input bit v);
      csr_write(v);
      csr_read_check(v);
   endtask

   // body byte plus the byte that follows a body escape
   function automatic void put_body(logic [7:0] b, logic [7:0] follower);
      stream_bytes.push_back(b);
      frame_bytes++;
      if (b == ESC_BYTE) begin
         stream_bytes.push_back(follower);
         frame_bytes++;
      end
   endfunction

   function automatic logic [7:0] any_follower();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
      return ESC_BYTE;
   endfunction

   function automatic logic [7:0] any_body_byte();
      if ($urandom_range(0, 9) == 0) return ESC_BYTE;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void put_header(logic [7:0] kind);
      stream_bytes.push_back(ESC_BYTE);
      stream_bytes.push_back(kind);
      frame_bytes += 2;
   endfunction

   // well-formed frame of random type and content, now and then cut short
   function automatic void put_random_frame();
      logic [7:0] kind;
      int body;
      case ($urandom_range(0, 2))
         0: begin
            kind = TYPE_MODEAC;
            body = 1 + STAMP_BYTES + MODEAC_PAYLOAD_BYTES;
         end
         1: begin
            kind = TYPE_SHORT;
            body = 1 + STAMP_BYTES + SHORT_PAYLOAD_BYTES;
         end
         default: begin
            kind = TYPE_LONG;
            body = 1 + STAMP_BYTES + LONG_PAYLOAD_BYTES;
         end
      endcase
      if ($urandom_range(0, 15) == 0) body = $urandom_range(0, body - 1);
      if ($urandom_range(0, 9) == 0) stream_bytes.push_back(ESC_BYTE);
      put_header(kind);
      repeat (body) put_body(any_body_byte(), any_follower());
   endfunction

   // stray bytes and headers with unknown types
   function automatic void put_noise();
      logic [7:0] b;
      if ($urandom_range(0, 1) == 0) begin
         repeat ($urandom_range(1, 8)) stream_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 2) == 0) b = 8'h35;
         else begin
            do b = 8'($urandom_range(0, 255));
            while (b == ESC_BYTE || b == TYPE_MODEAC || b == TYPE_SHORT || b == TYPE_LONG);
         end
         stream_bytes.push_back(ESC_BYTE);
         stream_bytes.push_back(b);
      end
   endfunction

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_read_check(1'b0);

      // directed: stray bytes, unknown type record, mode a/c dropped at reset value
      stream_bytes.push_back(8'h00);
      stream_bytes.push_back(8'hFF);
      put_header(8'h35);
      put_header(TYPE_MODEAC);
      repeat (7) put_body(8'h5A, ESC_BYTE);
      put_body(8'hFF, ESC_BYTE);
      put_body(8'hA5, ESC_BYTE);
      // escape in the type position, then a short frame with an escaped payload byte
      stream_bytes.push_back(ESC_BYTE);
      put_header(TYPE_SHORT);
      repeat (STAMP_BYTES) put_body(8'hFF, ESC_BYTE);
      put_body(8'h00, ESC_BYTE);
      put_body(8'h80, ESC_BYTE);
      put_body(ESC_BYTE, 8'h55);
      repeat (5) put_body(8'h01, ESC_BYTE);
      // long frame: escapes in stamp and signal, last payload byte an escape
      put_header(TYPE_LONG);
      put_body(8'h00, ESC_BYTE);
      put_body(ESC_BYTE, ESC_BYTE);
      repeat (3) put_body(8'h00, ESC_BYTE);
      put_body(8'h01, ESC_BYTE);
      put_body(ESC_BYTE, TYPE_LONG);
      repeat (13) put_body(8'hFF, ESC_BYTE);
      put_body(ESC_BYTE, ESC_BYTE);
      send_stream();
      wait_drained();

      // mode a/c passed once enabled
      set_accept_mode(1'b1);
      put_header(TYPE_MODEAC);
      repeat (STAMP_BYTES) put_body(8'h00, ESC_BYTE);
      put_body(8'hFF, ESC_BYTE);
      put_body(8'h00, ESC_BYTE);
      put_body(8'hFF, ESC_BYTE);
      send_stream();
      wait_drained();

      // random phases; the fourth holds off the receiver, the last runs without gaps
      for (int p = 0; p < PHASES; p++) begin
         set_accept_mode(accept_plan[p]);
         sender_gaps   = (p != PHASES - 1) && (p != 3);
         receiver_gaps = (p != PHASES - 1);
         frame_bytes   = 0;
         while (frame_bytes < PHASE_BYTES) begin
            if ($urandom_range(0, 6) == 0) put_noise();
            else put_random_frame();
         end
         if (p == 3) hold_request = 1;
         send_stream();
         wait_drained();
      end

      if (sb.errors == 0 && csr_errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> beast_binary_frame_deframer_unit.f
rtl/bbfd_pkg.sv
rtl/bbfd_front.sv
rtl/bbfd_queue.sv
rtl/bbfd_back.sv
rtl/beast_binary_frame_deframer_unit.sv
test/beast_binary_frame_deframer_unit_tb.sv
